// ===== rtl/tnc_pkg.sv =====
// shared constants and types of the tick to nanosecond converter
package tnc_pkg;

   localparam int WORD_BITS = 64;
   localparam int HALF_BITS = 32;
   // width of both dividends: 10^9 * 2^32 and lo * 10^9 stay below 2^62
   localparam int DIV_BITS  = 62;
   localparam int CNT_BITS  = $clog2(DIV_BITS + 1);
   localparam int IDX_BITS  = $clog2(DIV_BITS);

   localparam logic [29:0] NANOS_IN_SECOND = 30'd1000000000;
   localparam logic [WORD_BITS-1:0] RATE_RESET = 64'd1000000000;
   localparam logic [DIV_BITS-1:0] SCALE_NUM = {2'b00, NANOS_IN_SECOND, 30'd0} << 2;
   localparam logic [DIV_BITS-1:0] SCALE_RESET = DIV_BITS'(1) << HALF_BITS;

   typedef struct packed {
      logic [WORD_BITS-1:0] part_hi;
      logic                 ovf;
   } side_type;

endpackage

// ===== rtl/tnc_rate_cfg.sv =====
// tick rate register and iterative divider for the high-half scale
module tnc_rate_cfg import tnc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [WORD_BITS-1:0] csr_write_data,
   output logic [WORD_BITS-1:0] rate,
   output logic [DIV_BITS-1:0]  scale,
   output logic                 scale_busy
);

   logic [WORD_BITS-1:0] rate_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [WORD_BITS-1:0] rem_ff;
   logic [WORD_BITS-1:0] rem_in;
   logic [DIV_BITS-1:0]  quo_ff;
   logic [IDX_BITS-1:0]  bit_idx;
   logic [WORD_BITS:0]   r_ext;
   logic [WORD_BITS:0]   diff;

   assign bit_idx = IDX_BITS'(cnt_ff - CNT_BITS'(1));
   assign r_ext   = {rem_ff, SCALE_NUM[bit_idx]};
   assign diff    = r_ext - {1'b0, rate_ff};
   assign rem_in  = diff[WORD_BITS] ? r_ext[WORD_BITS-1:0] : diff[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         cnt_ff  <= '0;
         quo_ff  <= SCALE_RESET;
      end else if (csr_write_en) begin
         rate_ff <= csr_write_data;
         cnt_ff  <= CNT_BITS'(DIV_BITS);
         quo_ff  <= '0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
         quo_ff <= {quo_ff[DIV_BITS-2:0], ~diff[WORD_BITS]};
      end
   end

   // remainder restarts at zero on every write
   always_ff @(posedge clock) begin
      if (csr_write_en) begin
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
      end
   end

   assign rate       = rate_ff;
   assign scale      = quo_ff;
   assign scale_busy = (cnt_ff != '0);

endmodule

// ===== rtl/tnc_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
module tnc_div_pipe import tnc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [DIV_BITS-1:0]  in_num,
   input  side_type             in_side,
   input  logic [WORD_BITS-1:0] rate,
   output logic                 out_valid,
   output logic [DIV_BITS-1:0]  out_quo,
   output side_type             out_side
);

   logic                 valid_ff [DIV_BITS];
   logic [WORD_BITS-1:0] rem_ff   [DIV_BITS];
   logic [DIV_BITS-1:0]  num_ff   [DIV_BITS];
   logic [DIV_BITS-1:0]  quo_ff   [DIV_BITS];
   side_type             side_ff  [DIV_BITS];

   for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
      logic                 v_p;
      logic [WORD_BITS-1:0] rem_p;
      logic [DIV_BITS-1:0]  num_p;
      logic [DIV_BITS-1:0]  quo_p;
      side_type             side_p;
      logic [WORD_BITS:0]   r_ext;
      logic [WORD_BITS:0]   diff;

      if (s == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign num_p  = in_num;
         assign quo_p  = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = valid_ff[s-1];
         assign rem_p  = rem_ff[s-1];
         assign num_p  = num_ff[s-1];
         assign quo_p  = quo_ff[s-1];
         assign side_p = side_ff[s-1];
      end

      assign r_ext = {rem_p, num_p[DIV_BITS-1-s]};
      assign diff  = r_ext - {1'b0, rate};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= diff[WORD_BITS] ? r_ext[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
         num_ff[s]  <= num_p;
         quo_ff[s]  <= {quo_p[DIV_BITS-2:0], ~diff[WORD_BITS]};
         side_ff[s] <= side_p;
      end
   end

   assign out_valid = valid_ff[DIV_BITS-1];
   assign out_quo   = quo_ff[DIV_BITS-1];
   assign out_side  = side_ff[DIV_BITS-1];

endmodule

// ===== rtl/tick_to_nanosecond_converter_unit.sv =====
// top level of the tick to nanosecond converter
// Each request passes from the accepting edge to its rsp_valid cycle through a partial
// product stage, a stage that combines the high product and checks its overflow, a 62-stage
// divider for the low tick half, and the final add and overflow check.
// A new request can be taken every cycle while busy is low. After a write through csr_write_en
// the block runs the scale division and holds busy high while it runs; busy is otherwise low.
// Results appear on rsp_* for exactly one cycle each, in request order, and cannot be held off.
module tick_to_nanosecond_converter_unit import tnc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [WORD_BITS-1:0]        req_tick_count,
   input  logic                        csr_write_en,
   input  logic [WORD_BITS-1:0]        csr_write_data,
   output logic                        rsp_valid,
   output logic signed [WORD_BITS-1:0] rsp_nanoseconds,
   output logic                        rsp_overflowed
);

   logic [WORD_BITS-1:0] rate;
   logic [DIV_BITS-1:0]  scale;
   logic                 scale_busy;
   logic                 accept;

   logic                 valid1_ff;
   logic [DIV_BITS-1:0]  lo_prod_ff;
   logic [WORD_BITS-1:0] p_a_ff;
   logic [DIV_BITS-1:0]  p_b_ff;

   logic                 valid2_ff;
   logic [DIV_BITS-1:0]  num2_ff;
   side_type             side2_ff;
   side_type             side2_in;
   logic [WORD_BITS:0]   hi_sum;

   logic                 dv_valid;
   logic [DIV_BITS-1:0]  dv_quo;
   side_type             dv_side;
   logic [WORD_BITS-1:0] total;

   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] ns_ff;
   logic                 ovf_ff;

   tnc_rate_cfg u_rate_cfg (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rate           (rate),
      .scale          (scale),
      .scale_busy     (scale_busy)
   );

   assign busy   = scale_busy;
   assign accept = start & ~busy;

   // stage 1: partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      lo_prod_ff <= {30'd0, req_tick_count[HALF_BITS-1:0]} * {32'd0, NANOS_IN_SECOND};
      p_a_ff     <= {32'd0, req_tick_count[WORD_BITS-1:HALF_BITS]} *
                    {32'd0, scale[HALF_BITS-1:0]};
      p_b_ff     <= {30'd0, req_tick_count[WORD_BITS-1:HALF_BITS]} *
                    {32'd0, scale[DIV_BITS-1:HALF_BITS]};
   end

   // stage 2: high product and its overflow
   assign hi_sum = {1'b0, p_b_ff[HALF_BITS-1:0], 32'd0} + {1'b0, p_a_ff};
   assign side2_in.part_hi = hi_sum[WORD_BITS-1:0];
   assign side2_in.ovf     = (|p_b_ff[DIV_BITS-1:HALF_BITS]) | hi_sum[WORD_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      num2_ff  <= lo_prod_ff;
      side2_ff <= side2_in;
   end

   tnc_div_pipe u_div_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid2_ff),
      .in_num    (num2_ff),
      .in_side   (side2_ff),
      .rate      (rate),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // final add, sign check and zero rate
   assign total = dv_side.part_hi + {2'b00, dv_quo};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_side.ovf | total[WORD_BITS-1] | (rate == '0)) begin
         ns_ff  <= '1;
         ovf_ff <= 1'b1;
      end else begin
         ns_ff  <= total;
         ovf_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_nanoseconds = ns_ff;
   assign rsp_overflowed  = ovf_ff;

endmodule

// ===== tb/tnc_checker.sv =====
// checker: tracks the tick rate, predicts each conversion and compares the responses
module tnc_checker import tnc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [WORD_BITS-1:0]        req_tick_count,
   input  logic                        csr_write_en,
   input  logic [WORD_BITS-1:0]        csr_write_data,
   input  logic                        rsp_valid,
   input  logic signed [WORD_BITS-1:0] rsp_nanoseconds,
   input  logic                        rsp_overflowed,
   output int                          pending_count,
   output int                          error_count
);

   typedef struct packed {
      logic [WORD_BITS-1:0] ns;
      logic                 ovf;
   } ns_result_type;

   logic [WORD_BITS-1:0] rate_copy;
   ns_result_type        ns_queue[$];

   function automatic ns_result_type ticks_to_ns(logic [63:0] ticks, logic [63:0] rate);
      logic [63:0]   scale;
      logic [63:0]   part_lo;
      logic [63:0]   sum;
      logic [127:0]  part_hi;
      ns_result_type r;
      r.ns = '1;
      r.ovf = 1'b1;
      if (rate == 64'd0) begin
         return r;
      end
      scale = (64'd1000000000 << 32) / rate;
      part_hi = {96'd0, ticks[63:32]} * {64'd0, scale};
      // high product must fit in 64 bits
      if (part_hi[127:64] != 64'd0) begin
         return r;
      end
      part_lo = ({32'd0, ticks[31:0]} * 64'd1000000000) / rate;
      sum = part_hi[63:0] + part_lo;
      if (sum[63]) begin
         return r;
      end
      r.ns = sum;
      r.ovf = 1'b0;
      return r;
   endfunction

   assign pending_count = ns_queue.size();

   always @(posedge clock) begin
      ns_result_type exp_r;
      if (reset) begin
         rate_copy <= RATE_RESET;
         ns_queue.delete();
         error_count <= 0;
      end else begin
         if (csr_write_en) begin
            rate_copy <= csr_write_data;
         end
         if (start && !busy) begin
            ns_queue.push_back(ticks_to_ns(req_tick_count, rate_copy));
         end
         if (rsp_valid) begin
            if (ns_queue.size() == 0) begin
               if (error_count < 10) begin
                  $display("response with no request pending: ns=%h ovf=%b",
                           rsp_nanoseconds, rsp_overflowed);
               end
               error_count <= error_count + 1;
            end else begin
               exp_r = ns_queue.pop_front();
               if (exp_r.ns !== rsp_nanoseconds || exp_r.ovf !== rsp_overflowed) begin
                  if (error_count < 10) begin
                     $display("mismatch: expected ns=%h ovf=%b, got ns=%h ovf=%b",
                              exp_r.ns, exp_r.ovf, rsp_nanoseconds, rsp_overflowed);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// top of the converter testbench: stimulus, rate changes and verdict
module tb_top;
   import tnc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [WORD_BITS-1:0]        req_tick_count = '0;
   logic                        csr_write_en = 1'b0;
   logic [WORD_BITS-1:0]        csr_write_data = '0;
   logic                        rsp_valid;
   logic signed [WORD_BITS-1:0] rsp_nanoseconds;
   logic                        rsp_overflowed;
   int                          pending_count;
   int                          error_count;
   int                          cycle_count = 0;
   bit                          no_idle = 1'b0;

   always #5 clock = ~clock;

   tick_to_nanosecond_converter_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_tick_count(req_tick_count), .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data), .rsp_valid(rsp_valid),
      .rsp_nanoseconds(rsp_nanoseconds), .rsp_overflowed(rsp_overflowed)
   );

   tnc_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_tick_count(req_tick_count), .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data), .rsp_valid(rsp_valid),
      .rsp_nanoseconds(rsp_nanoseconds), .rsp_overflowed(rsp_overflowed),
      .pending_count(pending_count), .error_count(error_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // a request stays on the ports until an edge sees busy low
   task automatic send_request(logic [63:0] ticks);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_tick_count <= ticks;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_rate(logic [63:0] rate);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= rate;
      @(posedge clock);
      csr_write_en <= 1'b0;
      // scale division runs after each write
      @(posedge clock);
      while (!busy) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [63:0] random_ticks();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = v >> $urandom_range(0, 63);
         1: v = {v[63:32], 32'hffff_ffff} ^ (64'd1 << $urandom_range(0, 63));
         2: v = v & 64'h7fff_ffff_ffff_ffff;
         3: v = v >> $urandom_range(28, 40);
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] random_rate();
      logic [63:0] v;
      v = {$urandom, $urandom} >> $urandom_range(0, 63);
      if (v == 64'd0) v = 64'd1;
      return v;
   endfunction

   initial begin
      logic [63:0] directed[$];
      directed = '{64'd0, '1, 64'd1, 64'h0000_0000_ffff_ffff, 64'h0000_0001_0000_0000,
                   64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                   64'h0000_0000_7fff_ffff, 64'h0000_7fff_ffff_ffff,
                   64'h0000_8000_0000_0000, 64'h5555_5555_5555_5555,
                   64'haaaa_aaaa_aaaa_aaaa, 64'd1000000000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // reset rate, then the extreme rates and the zero rate
      foreach (directed[i]) send_request(directed[i]);
      write_rate(64'd1);
      foreach (directed[i]) send_request(directed[i]);
      write_rate('1);
      send_request('1);
      send_request(64'd0);
      send_request(64'h0000_0001_0000_0000);
      write_rate(64'd0);
      send_request(64'd0);
      send_request(64'h1234_5678_9abc_def0);

      for (int ph = 0; ph < 10; ph++) begin
         no_idle = (ph % 3 == 1);
         case (ph)
            0: write_rate(RATE_RESET);
            4: write_rate(64'd1);
            7: write_rate('1);
            default: write_rate(random_rate());
         endcase
         repeat (150) send_request(random_ticks());
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tnc_pkg.sv
rtl/tnc_rate_cfg.sv
rtl/tnc_div_pipe.sv
rtl/tick_to_nanosecond_converter_unit.sv
tb/tnc_checker.sv
tb/tb_top.sv
